/* src/polygonal_taper_filter_gain_assert.svh */
// assertion macros used by the checker file of the taper filter gain block
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef POLYGONAL_TAPER_FILTER_GAIN_ASSERT_SVH
`define POLYGONAL_TAPER_FILTER_GAIN_ASSERT_SVH

// same-cycle implication, off while reset is high
`define PTFG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is high
`define PTFG_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ptfg_pkg.sv */
// shared types, constants and the divider step of the taper filter gain block
// no dependencies; imported by every module of the block
package ptfg_pkg;

  localparam int FFT_SIZE  = 2048;
  localparam int HALF_BINS = FFT_SIZE / 2;
  localparam int N_CORNER  = 4;

  localparam int IDX_W  = 11;
  localparam int CFG_W  = 16;
  localparam int GAIN_W = 16;
  localparam int BIN_W  = $clog2(HALF_BINS + 1);
  localparam int DEN_W  = $clog2(HALF_BINS + 3);

  localparam int QF      = 30;
  localparam int XW      = 30;
  localparam int PW      = 31;
  localparam int TERM_W  = GAIN_W + 1;
  localparam int SCALE_W = GAIN_W + PW;

  localparam int DIV_BPS    = 3;
  localparam int DIV_STAGES = XW / DIV_BPS;
  localparam int POLY_STEPS = 4;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int N_REG     = 2 * N_CORNER;
  localparam int REG_IDX_W = $clog2(N_REG);
  localparam int ADDR_W    = REG_IDX_W + 2;
  localparam int DATA_W    = 32;

  localparam logic [CFG_W-1:0] BRK_RESET = '0;
  localparam logic [CFG_W-1:0] AMP_RESET = CFG_W'(4096);

  localparam logic [PW-1:0] Q30_ONE = PW'(64'd1 << QF);
  localparam logic [SCALE_W-1:0] ROUND_HALF = SCALE_W'(64'd1 << (QF - 1));

  // sine polynomial coefficients, innermost first
  localparam logic [PW-1:0] POLY_C [POLY_STEPS+1] = '{
    PW'(172272), PW'(5026995), PW'(85569306), PW'(693598668), PW'(1686629713)
  };

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BRK_BIN_0, REG_BRK_BIN_1, REG_BRK_BIN_2, REG_BRK_BIN_3,
    REG_AMP_0, REG_AMP_1, REG_AMP_2, REG_AMP_3
  } reg_idx_t;

  typedef struct packed {
    logic [N_CORNER-1:0][CFG_W-1:0] brk;
    logic [N_CORNER-1:0][CFG_W-1:0] amp;
  } cfg_t;

  // one classified bin: gain = base + d * taper(n / den)
  typedef struct packed {
    logic [DEN_W-1:0]  n;
    logic [DEN_W-1:0]  den;
    logic [GAIN_W-1:0] d;
    logic [GAIN_W-1:0] base;
  } job_t;

  typedef struct packed {
    logic             valid;
  } qlink_t;

  typedef struct packed {
    logic [DEN_W-1:0] r;
    logic [XW-1:0]    q;
  } div_st_t;

  // DIV_BPS (three) quotient bits of a restoring division
  function automatic div_st_t div_step(div_st_t cur, logic [DEN_W-1:0] den);
    div_st_t        nxt;
    logic [DEN_W:0] rr;
    nxt = cur;
    for (int i = 0; i < DIV_BPS; i++) begin
      rr = {nxt.r, 1'b0};
      if (rr >= {1'b0, den}) begin
        rr    = rr - {1'b0, den};
        nxt.q = {nxt.q[XW-2:0], 1'b1};
      end else begin
        nxt.q = {nxt.q[XW-2:0], 1'b0};
      end
      nxt.r = rr[DEN_W-1:0];
    end
    return nxt;
  endfunction

endpackage

/* src/ptfg_front.sv */
// front end: accepts a bin, clamps it and finds the segment that decides its gain
// depends on ptfg_pkg; feeds ptfg_queue
module ptfg_front import ptfg_pkg::*; (
  input  logic             bin_valid,
  output logic             bin_stall,
  input  logic [IDX_W-1:0] bin_index,
  input  cfg_t             cfg,
  input  logic             full,
  output logic             push,
  output job_t             job
);

  logic [N_CORNER-1:0][BIN_W-1:0] k;
  logic [BIN_W-1:0]               b;

  assign bin_stall = full;
  assign push      = bin_valid && !full;

  always_comb begin
    for (int i = 0; i < N_CORNER; i++) begin
      if (32'(cfg.brk[i]) > HALF_BINS) k[i] = BIN_W'(HALF_BINS);
      else                             k[i] = BIN_W'(cfg.brk[i]);
    end
    if (32'(bin_index) > HALF_BINS) b = BIN_W'(HALF_BINS);
    else                            b = BIN_W'(bin_index);
  end

  always_comb begin
    logic [BIN_W-1:0]  lo;
    logic [BIN_W-1:0]  hi;
    logic [GAIN_W-1:0] a0;
    logic [GAIN_W-1:0] a1;
    logic              tapered;
    job.n    = DEN_W'(1);
    job.den  = DEN_W'(2);
    job.d    = '0;
    job.base = '0;
    tapered  = 1'b0;
    if (b < k[0]) job.base = cfg.amp[0];
    for (int i = 0; i < N_CORNER - 1; i++) begin
      lo = k[i];
      hi = k[i+1];
      a0 = cfg.amp[i];
      a1 = cfg.amp[i+1];
      if (a0 != a1) begin
        if (hi >= lo && b >= lo && b <= hi) begin
          job.den = DEN_W'(hi - lo) + DEN_W'(2);
          if (a0 < a1) begin
            job.n    = DEN_W'(b - lo) + DEN_W'(1);
            job.d    = a1 - a0;
            job.base = a0;
          end else begin
            job.n    = DEN_W'(hi - b) + DEN_W'(1);
            job.d    = a0 - a1;
            job.base = a1;
          end
        end
        tapered = 1'b1;
      end else begin
        // flat step gives up its start bin once a taper came before
        if ((tapered ? (b > lo) : (b >= lo)) && b <= hi) begin
          job.n    = DEN_W'(1);
          job.den  = DEN_W'(2);
          job.d    = '0;
          job.base = a0;
        end
      end
    end
    if (b > k[N_CORNER-1]) begin
      job.n    = DEN_W'(1);
      job.den  = DEN_W'(2);
      job.d    = '0;
      job.base = cfg.amp[N_CORNER-1];
    end
  end

endmodule

/* src/ptfg_queue.sv */
// short job queue between the front end and the taper pipeline
// depends on ptfg_pkg
module ptfg_queue import ptfg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  job_t   job_in,
  output logic   full,
  output qlink_t link_out,
  input  logic   pop,
  output job_t   job_out
);

  job_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full           = (count == (Q_AW+1)'(Q_DEPTH));
  assign link_out.valid = (count != '0);
  assign job_out        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= job_in;
  end

endmodule

/* src/ptfg_back.sv */
// back end: divider, sine polynomial, square and gain scaling, one bin per cycle while gain_stall is low
// depends on ptfg_pkg; takes jobs from ptfg_queue
module ptfg_back import ptfg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  qlink_t            link_in,
  input  job_t              job,
  output logic              pop,
  output logic              gain_valid,
  input  logic              gain_stall,
  output logic [GAIN_W-1:0] gain
);

  typedef struct packed {
    logic [GAIN_W-1:0] d;
    logic [GAIN_W-1:0] base;
  } side_t;

  logic adv;

  // divider stages
  logic [DIV_STAGES-1:0] dv_vld;
  div_st_t               dv_st   [DIV_STAGES];
  logic [DEN_W-1:0]      dv_den  [DIV_STAGES];
  side_t                 dv_side [DIV_STAGES];

  // square of x
  logic          m0_vld;
  logic [XW-1:0] m0_x;
  logic [XW-1:0] m0_x2;
  side_t         m0_side;
  logic [2*XW-1:0] m0_prod;

  // polynomial steps
  logic [POLY_STEPS-1:0] pl_vld;
  logic [XW-1:0]         pl_x    [POLY_STEPS];
  logic [XW-1:0]         pl_x2   [POLY_STEPS];
  logic [PW-1:0]         pl_p    [POLY_STEPS];
  side_t                 pl_side [POLY_STEPS];

  logic          m5_vld;
  logic [PW-1:0] m5_s;
  side_t         m5_side;
  logic [XW+PW-1:0] m5_prod;

  logic          m6_vld;
  logic [PW-1:0] m6_s2;
  side_t         m6_side;
  logic [2*PW-1:0] m6_prod;

  logic              m7_vld;
  logic [TERM_W-1:0] m7_term;
  logic [GAIN_W-1:0] m7_base;
  logic [SCALE_W-1:0] m7_sum;

  logic              m8_vld;
  logic [GAIN_W-1:0] m8_gain;

  assign adv        = !(m8_vld && gain_stall);
  assign pop        = link_in.valid && adv;
  assign gain_valid = m8_vld;
  assign gain       = m8_gain;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    div_st_t          st_in;
    logic [DEN_W-1:0] den_in;
    side_t            side_in;
    logic             vld_in;
    if (s == 0) begin : g_first
      assign st_in.r   = job.n;
      assign st_in.q   = '0;
      assign den_in    = job.den;
      assign side_in.d    = job.d;
      assign side_in.base = job.base;
      assign vld_in    = link_in.valid;
    end else begin : g_rest
      assign st_in   = dv_st[s-1];
      assign den_in  = dv_den[s-1];
      assign side_in = dv_side[s-1];
      assign vld_in  = dv_vld[s-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[s] <= 1'b0;
      end else if (adv) begin
        dv_vld[s] <= vld_in;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_st[s]   <= div_step(st_in, den_in);
        dv_den[s]  <= den_in;
        dv_side[s] <= side_in;
      end
    end
  end

  assign m0_prod = dv_st[DIV_STAGES-1].q * dv_st[DIV_STAGES-1].q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m0_vld <= 1'b0;
    end else if (adv) begin
      m0_vld <= dv_vld[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m0_x    <= dv_st[DIV_STAGES-1].q;
      m0_x2   <= m0_prod[2*XW-1:QF];
      m0_side <= dv_side[DIV_STAGES-1];
    end
  end

  for (genvar j = 0; j < POLY_STEPS; j++) begin : g_poly
    logic [XW-1:0]    x_in;
    logic [XW-1:0]    x2_in;
    logic [PW-1:0]    p_in;
    side_t            side_in;
    logic             vld_in;
    logic [XW+PW-1:0] prod;
    if (j == 0) begin : g_first
      assign x_in    = m0_x;
      assign x2_in   = m0_x2;
      assign p_in    = POLY_C[0];
      assign side_in = m0_side;
      assign vld_in  = m0_vld;
    end else begin : g_rest
      assign x_in    = pl_x[j-1];
      assign x2_in   = pl_x2[j-1];
      assign p_in    = pl_p[j-1];
      assign side_in = pl_side[j-1];
      assign vld_in  = pl_vld[j-1];
    end
    assign prod = x2_in * p_in;
    always_ff @(posedge clk) begin
      if (rst) begin
        pl_vld[j] <= 1'b0;
      end else if (adv) begin
        pl_vld[j] <= vld_in;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        pl_x[j]    <= x_in;
        pl_x2[j]   <= x2_in;
        pl_p[j]    <= POLY_C[j+1] - prod[XW+PW-1:QF];
        pl_side[j] <= side_in;
      end
    end
  end

  assign m5_prod = pl_x[POLY_STEPS-1] * pl_p[POLY_STEPS-1];
  assign m6_prod = m5_s * m5_s;
  assign m7_sum  = m6_side.d * m6_s2 + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      m5_vld <= 1'b0;
      m6_vld <= 1'b0;
      m7_vld <= 1'b0;
      m8_vld <= 1'b0;
    end else if (adv) begin
      m5_vld <= pl_vld[POLY_STEPS-1];
      m6_vld <= m5_vld;
      m7_vld <= m6_vld;
      m8_vld <= m7_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m5_s    <= m5_prod[XW+PW-1:QF];
      m5_side <= pl_side[POLY_STEPS-1];
      // sin squared, capped at one
      if (m6_prod[2*PW-1:QF] > {1'b0, Q30_ONE}) m6_s2 <= Q30_ONE;
      else                                      m6_s2 <= m6_prod[QF+PW-1:QF];
      m6_side <= m5_side;
      m7_term <= m7_sum[SCALE_W-1:QF];
      m7_base <= m6_side.base;
      m8_gain <= GAIN_W'({1'b0, m7_base} + m7_term);
    end
  end

endmodule

/* src/polygonal_taper_filter_gain.sv */
// Polygonal four-corner filter gain with sin^2 tapers. One bin_index is accepted per cycle
// and one gain leaves per cycle when gain_stall stays low; a bin passes the queue, then the
// ten-stage divider that forms (offset+1)/(span+2) three quotient bits a stage, then the
// nine-stage multiply chain for the sine polynomial, its square and the gain scaling. A
// four-deep queue sits between the classifying front end and that pipeline. Corner bins and
// bin_index saturate at FFT_SIZE/2; gains are unsigned Q4.12. Registers sit at byte addresses
// 0x00 to 0x1c (four corner bins, then four corner gains). The user must see that they are
// written only while no bin is in flight; the block itself does not enforce this.
module polygonal_taper_filter_gain import ptfg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              bin_valid,
  output logic              bin_stall,
  input  logic [IDX_W-1:0]  bin_index,
  output logic              gain_valid,
  input  logic              gain_stall,
  output logic [GAIN_W-1:0] gain
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_wr;
  logic     full;
  logic     push;
  logic     pop;
  job_t     job_in;
  job_t     job_out;
  qlink_t   link;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N_CORNER; i++) begin
        cfg.brk[i] <= BRK_RESET;
        cfg.amp[i] <= AMP_RESET;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BRK_BIN_0: cfg.brk[0] <= pwdata[CFG_W-1:0];
        REG_BRK_BIN_1: cfg.brk[1] <= pwdata[CFG_W-1:0];
        REG_BRK_BIN_2: cfg.brk[2] <= pwdata[CFG_W-1:0];
        REG_BRK_BIN_3: cfg.brk[3] <= pwdata[CFG_W-1:0];
        REG_AMP_0:     cfg.amp[0] <= pwdata[CFG_W-1:0];
        REG_AMP_1:     cfg.amp[1] <= pwdata[CFG_W-1:0];
        REG_AMP_2:     cfg.amp[2] <= pwdata[CFG_W-1:0];
        REG_AMP_3:     cfg.amp[3] <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BRK_BIN_0: prdata = DATA_W'(cfg.brk[0]);
      REG_BRK_BIN_1: prdata = DATA_W'(cfg.brk[1]);
      REG_BRK_BIN_2: prdata = DATA_W'(cfg.brk[2]);
      REG_BRK_BIN_3: prdata = DATA_W'(cfg.brk[3]);
      REG_AMP_0:     prdata = DATA_W'(cfg.amp[0]);
      REG_AMP_1:     prdata = DATA_W'(cfg.amp[1]);
      REG_AMP_2:     prdata = DATA_W'(cfg.amp[2]);
      REG_AMP_3:     prdata = DATA_W'(cfg.amp[3]);
      default:       prdata = '0;
    endcase
  end

  ptfg_front u_front (
    .bin_valid (bin_valid),
    .bin_stall (bin_stall),
    .bin_index (bin_index),
    .cfg       (cfg),
    .full      (full),
    .push      (push),
    .job       (job_in)
  );

  ptfg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .job_in   (job_in),
    .full     (full),
    .link_out (link),
    .pop      (pop),
    .job_out  (job_out)
  );

  ptfg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .link_in    (link),
    .job        (job_out),
    .pop        (pop),
    .gain_valid (gain_valid),
    .gain_stall (gain_stall),
    .gain       (gain)
  );

endmodule

/* src/ptfg_check.sv */
// port checker for the taper filter gain block, bound to the top level
// depends on ptfg_pkg and polygonal_taper_filter_gain_assert.svh
`include "polygonal_taper_filter_gain_assert.svh"

module ptfg_check import ptfg_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready,
  input logic              bin_valid,
  input logic              bin_stall,
  input logic              gain_valid,
  input logic              gain_stall,
  input logic [GAIN_W-1:0] gain
);

  // a stalled gain beat holds
  `PTFG_ASSERT_NXT(a_gain_hold, clk, rst, gain_valid && gain_stall, gain_valid && $stable(gain), "gain beat changed while stalled")

  // no result straight out of reset
  `PTFG_ASSERT_IMP(a_reset_empty, clk, rst, $past(rst), !gain_valid, "gain valid right after reset")

  // the queue only fills when a bin beat was taken
  `PTFG_ASSERT_IMP(a_stall_cause, clk, rst, $rose(bin_stall), $past(bin_valid && !bin_stall), "bin stall rose without an accepted beat")

  // a written register reads back
  `PTFG_ASSERT_IMP(a_readback, clk, rst, $past(psel && penable && pwrite && pready) && paddr == $past(paddr), prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]), "register read back mismatch")

endmodule

bind polygonal_taper_filter_gain ptfg_check u_check (.*);
